### rtl/core/opu_pkg.sv
// ----------------------------------------------------------------------------
// opu_pkg
// Shared types, register and mode codes, and pipeline sizes for the
// optimizer parameter update core.
// ----------------------------------------------------------------------------
`default_nettype none

package opu_pkg;

  // Depth of each average store. Element numbers wrap onto the store by
  // keeping the low address bits, so this is kept at a power of two.
  localparam int ELEMENTS = 256;
  localparam int ADDR_W   = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

  localparam logic [1:0] MODE_PLAIN    = 2'd0;
  localparam logic [1:0] MODE_MOMENTUM = 2'd1;
  localparam logic [1:0] MODE_ADAPTIVE = 2'd2;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_DECAY = 2'd1;
  localparam logic [1:0] REG_RATE  = 2'd2;

  localparam logic [15:0] DECAY_RST = 16'd58982;
  localparam logic [23:0] RATE_RST  = 24'd16777;

  // Epsilon of 0.000001 in Q8.24, rounded.
  localparam logic [28:0] EPS_Q24 = 29'd17;

  // Square root: 28 result bits, two per stage.
  localparam int SQRT_BITS = 28;
  localparam int SQRT_ST   = SQRT_BITS / 2;
  // Divider: 34 quotient bits (the top one flags saturation), two per stage,
  // behind one stage that forms the divisor and the magnitude.
  localparam int QUO_BITS  = 34;
  localparam int DIV_ST    = QUO_BITS / 2;
  localparam int DIV_LAT   = DIV_ST + 1;
  localparam int NUM_W     = 56;

  typedef struct packed {
    logic [7:0]         element_index;
    logic signed [31:0] weight_in;
    logic signed [31:0] bias_in;
    logic signed [31:0] weight_grad;
    logic signed [31:0] bias_grad;
  } opu_in_t;

  typedef struct packed {
    logic [7:0]         element_out;
    logic signed [31:0] weight_out;
    logic signed [31:0] bias_out;
  } opu_out_t;

  // What travels beside the square root and divider.
  typedef struct packed {
    logic [7:0]         idx;
    logic signed [31:0] w;
    logic signed [31:0] b;
    logic signed [31:0] dw_w;
    logic signed [31:0] dw_b;
    logic               use_div;
  } opu_side_t;

  typedef struct packed {
    opu_side_t          side;
    logic signed [31:0] avg_w;
    logic signed [31:0] avg_b;
    logic [31:0]        sq_w;
    logic [31:0]        sq_b;
  } opu_upd_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if ((v[35:31] == 5'b00000) || (v[35:31] == 5'b11111)) begin
      return v[31:0];
    end
    return v[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

endpackage

`default_nettype wire

### rtl/core/optimizer_parameter_update_core.sv
// ----------------------------------------------------------------------------
// optimizer_parameter_update_core
// Updates one element's weight and bias per cycle in plain, momentum or
// adaptive mode; a new request is taken every cycle while the result side
// does not stall. The pipeline is 36 stages long: the three front stages
// that update the averages, the 14-stage square root, the 18-stage divider
// and the output register. A stall on the result side freezes the whole
// pipeline and is passed straight back to the request side. The average
// stores carry one valid bit per element, so reset and a mode write clear
// them at once, with no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module optimizer_parameter_update_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  opu_pkg::opu_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output opu_pkg::opu_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [23:0]       cfg_data
);
  import opu_pkg::*;

  localparam int LAT = SQRT_ST + DIV_LAT;

  logic               adv;
  logic               cfg_wr;
  logic               clr;
  logic [1:0]         mode_r;
  logic [15:0]        decay_r;
  logic [23:0]        rate_r;

  logic               upd_vld;
  opu_upd_t           upd;

  logic [SQRT_BITS-1:0]    root_w, root_b;
  logic signed [NUM_W-1:0] num_w_nxt, num_b_nxt;
  logic signed [NUM_W-1:0] num_w_r [SQRT_ST];
  logic signed [NUM_W-1:0] num_b_r [SQRT_ST];
  logic [QUO_BITS-1:0]     q_w, q_b;
  logic                    neg_w, neg_b;

  opu_side_t          sb_r [LAT];
  logic [LAT-1:0]     sb_vld_r;
  opu_side_t          side;

  logic signed [35:0] aw, ab, bw, bb, sum_w, sum_b;
  logic               out_valid_r;
  opu_out_t           out_data_r, out_data_nxt;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign clr       = cfg_wr && (cfg_index == REG_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_PLAIN;
      decay_r <= DECAY_RST;
      rate_r  <= RATE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_MODE:  mode_r  <= cfg_data[1:0];
        REG_DECAY: decay_r <= cfg_data[15:0];
        REG_RATE:  rate_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  opu_avg_update u_avg (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .clr     (clr),
    .mode    (mode_r),
    .decay   (decay_r),
    .in_vld  (in_valid),
    .in_data (in_data),
    .upd_vld (upd_vld),
    .upd     (upd)
  );

  opu_isqrt u_sqrt_w (
    .clk  (clk),
    .en   (adv),
    .x    ({upd.sq_w, 24'd0}),
    .root (root_w)
  );

  opu_isqrt u_sqrt_b (
    .clk  (clk),
    .en   (adv),
    .x    ({upd.sq_b, 24'd0}),
    .root (root_b)
  );

  // Dividend avg * rate, held until the matching root is ready.
  assign num_w_nxt = upd.avg_w * $signed({1'b0, rate_r});
  assign num_b_nxt = upd.avg_b * $signed({1'b0, rate_r});

  always_ff @(posedge clk) begin
    if (adv) begin
      num_w_r[0] <= num_w_nxt;
      num_b_r[0] <= num_b_nxt;
      for (int k = 1; k < SQRT_ST; k++) begin
        num_w_r[k] <= num_w_r[k-1];
        num_b_r[k] <= num_b_r[k-1];
      end
    end
  end

  opu_div u_div_w (
    .clk  (clk),
    .en   (adv),
    .num  (num_w_r[SQRT_ST-1]),
    .root (root_w),
    .quo  (q_w),
    .neg  (neg_w)
  );

  opu_div u_div_b (
    .clk  (clk),
    .en   (adv),
    .num  (num_b_r[SQRT_ST-1]),
    .root (root_b),
    .quo  (q_b),
    .neg  (neg_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_vld_r <= '0;
    end else if (adv) begin
      sb_vld_r <= {sb_vld_r[LAT-2:0], upd_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r[0] <= upd.side;
      for (int k = 1; k < LAT; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  assign side = sb_r[LAT-1];

  always_comb begin
    aw = 36'(side.w);
    ab = 36'(side.b);
    bw = $signed({2'b00, q_w});
    bb = $signed({2'b00, q_b});
    if (side.use_div) begin
      sum_w = neg_w ? aw - bw : aw + bw;
      sum_b = neg_b ? ab - bb : ab + bb;
    end else begin
      sum_w = aw + 36'(side.dw_w);
      sum_b = ab + 36'(side.dw_b);
    end
    out_data_nxt.element_out = side.idx;
    out_data_nxt.weight_out  = sat32(sum_w);
    out_data_nxt.bias_out    = sat32(sum_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sb_vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### rtl/core/opu_avg_update.sv
// ----------------------------------------------------------------------------
// opu_avg_update
// Front three stages: gradient products, squared gradient terms, and the
// read-modify-write of the four average stores with forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module opu_avg_update (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             clr,
  input  logic [1:0]       mode,
  input  logic [15:0]      decay,
  input  logic             in_vld,
  input  opu_pkg::opu_in_t in_data,
  output logic             upd_vld,
  output opu_pkg::opu_upd_t upd
);
  import opu_pkg::*;

  typedef struct packed {
    logic [7:0]         idx;
    logic [ADDR_W-1:0]  e;
    logic signed [31:0] w;
    logic signed [31:0] b;
    logic signed [31:0] gw;
    logic signed [31:0] gb;
    logic signed [49:0] gt_w;
    logic signed [49:0] gt_b;
    logic [63:0]        sqp_w;
    logic [63:0]        sqp_b;
  } st1_t;

  typedef struct packed {
    logic [7:0]         idx;
    logic [ADDR_W-1:0]  e;
    logic signed [31:0] w;
    logic signed [31:0] b;
    logic signed [31:0] gw;
    logic signed [31:0] gb;
    logic signed [49:0] gt_w;
    logic signed [49:0] gt_b;
    logic [48:0]        st_w;
    logic [48:0]        st_b;
  } st2_t;

  logic [16:0]        dinv;
  logic               upd_en;
  logic               v1_r, v2_r, v3_r;
  st1_t               s1_r, s1_nxt;
  st2_t               s2_r, s2_nxt;
  opu_upd_t           upd_r, upd_nxt;
  logic [ADDR_W-1:0]  e3_r;

  logic [31:0]        mag_w, mag_b;
  logic signed [48:0] pg_w, pg_b;
  logic [31:0]        sq_w, sq_b;

  logic               byp;
  logic signed [31:0] ow, ob;
  logic [31:0]        osw, osb;
  logic signed [48:0] pa_w, pa_b;
  logic signed [49:0] acc_w, acc_b, shw, shb;
  logic [47:0]        ps_w, ps_b;
  logic [49:0]        ss_w, ss_b;
  logic               wr;

  logic signed [31:0] w_avg_r [ELEMENTS];
  logic signed [31:0] b_avg_r [ELEMENTS];
  logic [31:0]        w_sq_r  [ELEMENTS];
  logic [31:0]        b_sq_r  [ELEMENTS];
  logic [ELEMENTS-1:0] ok_r;
  logic signed [31:0] rd_w_r, rd_b_r;
  logic [31:0]        rd_sw_r, rd_sb_r;
  logic               rd_ok_r;

  assign dinv   = 17'h10000 - {1'b0, decay};
  assign upd_en = (mode == MODE_MOMENTUM) || (mode == MODE_ADAPTIVE);

  // Stage 1: gradient times (1 - decay) with the rounding constant, and the
  // full square of each gradient magnitude.
  always_comb begin
    mag_w = in_data.weight_grad[31] ? 32'(-in_data.weight_grad) : in_data.weight_grad;
    mag_b = in_data.bias_grad[31] ? 32'(-in_data.bias_grad) : in_data.bias_grad;
    pg_w  = in_data.weight_grad * $signed({1'b0, dinv});
    pg_b  = in_data.bias_grad * $signed({1'b0, dinv});
    s1_nxt.idx   = in_data.element_index;
    s1_nxt.e     = ADDR_W'(in_data.element_index);
    s1_nxt.w     = in_data.weight_in;
    s1_nxt.b     = in_data.bias_in;
    s1_nxt.gw    = in_data.weight_grad;
    s1_nxt.gb    = in_data.bias_grad;
    s1_nxt.gt_w  = 50'(pg_w) + 50'sd32768;
    s1_nxt.gt_b  = 50'(pg_b) + 50'sd32768;
    s1_nxt.sqp_w = 64'(mag_w) * 64'(mag_w);
    s1_nxt.sqp_b = 64'(mag_b) * 64'(mag_b);
  end

  // Stage 2: square in Q8.24, saturated, times (1 - decay) plus rounding.
  always_comb begin
    sq_w = (|s1_r.sqp_w[63:56]) ? 32'hFFFF_FFFF : s1_r.sqp_w[55:24];
    sq_b = (|s1_r.sqp_b[63:56]) ? 32'hFFFF_FFFF : s1_r.sqp_b[55:24];
    s2_nxt.idx  = s1_r.idx;
    s2_nxt.e    = s1_r.e;
    s2_nxt.w    = s1_r.w;
    s2_nxt.b    = s1_r.b;
    s2_nxt.gw   = s1_r.gw;
    s2_nxt.gb   = s1_r.gb;
    s2_nxt.gt_w = s1_r.gt_w;
    s2_nxt.gt_b = s1_r.gt_b;
    s2_nxt.st_w = 49'(sq_w) * 49'(dinv) + 49'd32768;
    s2_nxt.st_b = 49'(sq_b) * 49'(dinv) + 49'd32768;
  end

  // Stage 3: the store read landed while the item sat in stage 2. When the
  // item just ahead updated the same element, its fresh values are taken
  // from the stage 3 register instead.
  always_comb begin
    byp = v3_r && upd_en && (e3_r == s2_r.e);
    ow  = byp ? upd_r.avg_w : (rd_ok_r ? rd_w_r : 32'sd0);
    ob  = byp ? upd_r.avg_b : (rd_ok_r ? rd_b_r : 32'sd0);
    osw = byp ? upd_r.sq_w : (rd_ok_r ? rd_sw_r : 32'd0);
    osb = byp ? upd_r.sq_b : (rd_ok_r ? rd_sb_r : 32'd0);

    pa_w  = ow * $signed({1'b0, decay});
    pa_b  = ob * $signed({1'b0, decay});
    acc_w = 50'(pa_w) + s2_r.gt_w;
    acc_b = 50'(pa_b) + s2_r.gt_b;
    shw   = acc_w >>> 16;
    shb   = acc_b >>> 16;
    ps_w  = 48'(osw) * 48'(decay);
    ps_b  = 48'(osb) * 48'(decay);
    ss_w  = 50'(ps_w) + 50'(s2_r.st_w);
    ss_b  = 50'(ps_b) + 50'(s2_r.st_b);

    upd_nxt.avg_w = sat32(shw[35:0]);
    upd_nxt.avg_b = sat32(shb[35:0]);
    upd_nxt.sq_w  = (mode == MODE_ADAPTIVE) ? ss_w[47:16] : osw;
    upd_nxt.sq_b  = (mode == MODE_ADAPTIVE) ? ss_b[47:16] : osb;

    upd_nxt.side.idx     = s2_r.idx;
    upd_nxt.side.w       = s2_r.w;
    upd_nxt.side.b       = s2_r.b;
    upd_nxt.side.use_div = (mode == MODE_ADAPTIVE);
    upd_nxt.side.dw_w    = (mode == MODE_MOMENTUM) ? upd_nxt.avg_w : s2_r.gw;
    upd_nxt.side.dw_b    = (mode == MODE_MOMENTUM) ? upd_nxt.avg_b : s2_r.gb;
  end

  assign wr = adv && v2_r && upd_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      upd_r <= upd_nxt;
      e3_r  <= s2_r.e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r <= '0;
    end else if (clr) begin
      ok_r <= '0;
    end else if (wr) begin
      ok_r[s2_r.e] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_w_r  <= w_avg_r[s1_r.e];
      rd_b_r  <= b_avg_r[s1_r.e];
      rd_sw_r <= w_sq_r[s1_r.e];
      rd_sb_r <= b_sq_r[s1_r.e];
      rd_ok_r <= ok_r[s1_r.e];
      if (wr) begin
        w_avg_r[s2_r.e] <= upd_nxt.avg_w;
        b_avg_r[s2_r.e] <= upd_nxt.avg_b;
        w_sq_r[s2_r.e]  <= upd_nxt.sq_w;
        b_sq_r[s2_r.e]  <= upd_nxt.sq_b;
      end
    end
  end

  assign upd_vld = v3_r;
  assign upd     = upd_r;

endmodule

`default_nettype wire

### rtl/core/opu_isqrt.sv
// ----------------------------------------------------------------------------
// opu_isqrt
// Pipelined integer square root, two result bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module opu_isqrt (
  input  logic                           clk,
  input  logic                           en,
  input  logic [2*opu_pkg::SQRT_BITS-1:0] x,
  output logic [opu_pkg::SQRT_BITS-1:0]   root
);
  import opu_pkg::*;

  typedef struct packed {
    logic [2*SQRT_BITS-1:0] rem;
    logic [SQRT_BITS-1:0]   root;
  } sq_t;

  // Remainder holds x - root^2; bit i is kept when (root + 2^i)^2 still fits.
  function automatic sq_t sqrt_step(input sq_t s, input int i);
    logic [2*SQRT_BITS+1:0] t;
    sq_t r;
    r = s;
    t = ((2*SQRT_BITS+2)'(s.root) << (i + 1)) + ((2*SQRT_BITS+2)'(1) << (2 * i));
    if ((2*SQRT_BITS+2)'(s.rem) >= t) begin
      r.rem     = s.rem - t[2*SQRT_BITS-1:0];
      r.root[i] = 1'b1;
    end
    return r;
  endfunction

  sq_t st_r  [SQRT_ST];
  sq_t st_in [SQRT_ST];

  assign st_in[0] = '{rem: x, root: '0};

  for (genvar k = 0; k < SQRT_ST; k++) begin : g_st
    if (k > 0) begin : g_link
      assign st_in[k] = st_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= sqrt_step(sqrt_step(st_in[k], 2*(SQRT_ST-k)-1), 2*(SQRT_ST-k)-2);
      end
    end
  end

  assign root = st_r[SQRT_ST-1].root;

endmodule

`default_nettype wire

### rtl/core/opu_div.sv
// ----------------------------------------------------------------------------
// opu_div
// Pipelined signed-by-unsigned restoring divider, truncating toward zero,
// with the divisor formed as root plus epsilon.
// ----------------------------------------------------------------------------
`default_nettype none

module opu_div (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [opu_pkg::NUM_W-1:0]  num,
  input  logic [opu_pkg::SQRT_BITS-1:0]     root,
  output logic [opu_pkg::QUO_BITS-1:0]      quo,
  output logic                              neg
);
  import opu_pkg::*;

  localparam int DEN_W = SQRT_BITS + 1;
  localparam int T_W   = DEN_W + QUO_BITS;

  typedef struct packed {
    logic [NUM_W-1:0]    rem;
    logic [DEN_W-1:0]    den;
    logic [QUO_BITS-1:0] q;
    logic                neg;
  } dv_t;

  function automatic dv_t div_step(input dv_t s, input int i);
    logic [T_W-1:0] t;
    dv_t r;
    r = s;
    t = T_W'(s.den) << i;
    if (T_W'(s.rem) >= t) begin
      r.rem  = s.rem - t[NUM_W-1:0];
      r.q[i] = 1'b1;
    end
    return r;
  endfunction

  dv_t pre_r, pre_nxt;
  dv_t st_r  [DIV_ST];
  dv_t st_in [DIV_ST];

  // The top quotient bit is set only when the quotient cannot fit in 33 bits;
  // the lower bits are then meaningless but the sum saturates anyway.
  always_comb begin
    pre_nxt.rem = num[NUM_W-1] ? NUM_W'(-num) : num;
    pre_nxt.den = DEN_W'(root) + EPS_Q24;
    pre_nxt.q   = '0;
    pre_nxt.neg = num[NUM_W-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_r <= pre_nxt;
    end
  end

  assign st_in[0] = pre_r;

  for (genvar k = 0; k < DIV_ST; k++) begin : g_st
    if (k > 0) begin : g_link
      assign st_in[k] = st_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= div_step(div_step(st_in[k], 2*(DIV_ST-k)-1), 2*(DIV_ST-k)-2);
      end
    end
  end

  assign quo = st_r[DIV_ST-1].q;
  assign neg = st_r[DIV_ST-1].neg;

endmodule

`default_nettype wire

### bench/optimizer_parameter_update_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// optimizer_parameter_update_core_tb
// Streams element updates through the core in plain, momentum and adaptive
// modes and under several decay and rate settings. A local model of the
// average stores predicts every result, and the monitor checks each one in
// order. Both sides pause at random, and the bench also holds the result side
// off long enough to back the pipeline up into the request side.
// ----------------------------------------------------------------------------
module optimizer_parameter_update_core_tb;
  import opu_pkg::*;

  localparam int LAT_WAIT   = 50;
  localparam int IDLE_LIMIT = 3000;
  localparam int RAND_ITEMS = 100;

  // Mode value with no meaning of its own, and a register index with no register.
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [1:0] REG_SPARE  = 2'd3;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  opu_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  opu_out_t out_data;
  logic     cfg_valid;
  logic     cfg_ready;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;

  optimizer_parameter_update_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Local copy of the configuration and the average stores.
  logic [1:0]  upd_mode;
  int unsigned upd_decay;
  int unsigned upd_rate;
  int          w_avg [ELEMENTS];
  int          b_avg [ELEMENTS];
  int unsigned w_sq  [ELEMENTS];
  int unsigned b_sq  [ELEMENTS];

  opu_in_t  pending_requests [$];
  opu_out_t expected_updates [$];

  int  mismatches;
  int  results_seen;
  int  idle_cycles;
  bit  in_taken;
  bit  quiet;
  bit  long_hold_req;
  bit  sender_hold;
  int  tx_gap;
  int  rx_left;

  function automatic longint sat_q24(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned b_pos;
    r = 0;
    b_pos = 64'h4000_0000_0000_0000;
    while (b_pos > v) b_pos = b_pos >> 2;
    while (b_pos != 0) begin
      if (v >= r + b_pos) begin
        v = v - (r + b_pos);
        r = (r >> 1) + b_pos;
      end else begin
        r = r >> 1;
      end
      b_pos = b_pos >> 2;
    end
    return r;
  endfunction

  function automatic int decayed_avg(int avg, longint g);
    longint s;
    s = longint'(avg) * longint'(upd_decay) + g * longint'(65536 - upd_decay) + 32768;
    return int'(sat_q24(s >>> 16));
  endfunction

  function automatic int unsigned decayed_sq(int unsigned sq_avg, longint g);
    longint unsigned mag;
    longint unsigned sq;
    longint unsigned s;
    mag = (g < 0) ? longint'(-g) : g;
    sq = (mag * mag) >> 24;
    if (sq > 64'hFFFF_FFFF) sq = 64'hFFFF_FFFF;
    s = longint'(sq_avg) * upd_decay + sq * (65536 - upd_decay) + 32768;
    return int'(s >> 16);
  endfunction

  function automatic longint adaptive_delta(int avg, int unsigned sq_avg);
    longint den;
    longint num;
    den = longint'(root_floor(longint'(sq_avg) << 24)) + 17;
    num = longint'(avg) * longint'(upd_rate);
    return num / den;
  endfunction

  function automatic opu_out_t predict_update(opu_in_t rq);
    opu_out_t res;
    int e;
    longint dw;
    longint db;
    e = rq.element_index % ELEMENTS;
    if (upd_mode == MODE_MOMENTUM || upd_mode == MODE_ADAPTIVE) begin
      w_avg[e] = decayed_avg(w_avg[e], rq.weight_grad);
      b_avg[e] = decayed_avg(b_avg[e], rq.bias_grad);
      if (upd_mode == MODE_ADAPTIVE) begin
        w_sq[e] = decayed_sq(w_sq[e], rq.weight_grad);
        b_sq[e] = decayed_sq(b_sq[e], rq.bias_grad);
        dw = adaptive_delta(w_avg[e], w_sq[e]);
        db = adaptive_delta(b_avg[e], b_sq[e]);
      end else begin
        dw = w_avg[e];
        db = b_avg[e];
      end
    end else begin
      dw = rq.weight_grad;
      db = rq.bias_grad;
    end
    res.element_out = rq.element_index;
    res.weight_out  = 32'(sat_q24(longint'(rq.weight_in) + dw));
    res.bias_out    = 32'(sat_q24(longint'(rq.bias_in) + db));
    return res;
  endfunction

  function automatic void clear_averages();
    foreach (w_avg[i]) begin
      w_avg[i] = 0;
      b_avg[i] = 0;
      w_sq[i]  = 0;
      b_sq[i]  = 0;
    end
  endfunction

  // Monitor: requests, results and the idle watchdog, all at the rising edge.
  always @(posedge clk) begin
    opu_out_t exp_res;
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken)
      expected_updates.insert(expected_updates.size(), predict_update(in_data));
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_updates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", out_data);
      end else begin
        exp_res = expected_updates.pop_front();
        if (out_data.element_out !== exp_res.element_out ||
            out_data.weight_out !== exp_res.weight_out ||
            out_data.bias_out !== exp_res.bias_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected elem %0d w %h b %h, got elem %0d w %h b %h",
                     exp_res.element_out, exp_res.weight_out, exp_res.bias_out,
                     out_data.element_out, out_data.weight_out, out_data.bias_out);
        end
      end
    end
    if (!rst_n || in_taken || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout with %0d results outstanding", expected_updates.size());
      $display("optimizer_parameter_update_core test failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Request driver: a new request goes up once the previous one is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() > 0 && !sender_hold) begin
        in_data  <= pending_requests.pop_front();
        in_valid <= 1'b1;
        tx_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side stall pattern; a long hold-off is counted here on request.
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 0;
      rx_left = 300;
    end
    if (rx_left > 0) begin
      rx_left--;
      out_stall <= 1'b1;
    end else if (quiet || $urandom_range(0, 99) < 70) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b1;
      rx_left = pick_gap();
    end
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1: return $urandom();
      2, 3: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      4: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  task automatic queue_request(int idx, int w, int b, int gw, int gb);
    opu_in_t rq;
    rq.element_index = 8'(idx);
    rq.weight_in     = w;
    rq.bias_in       = b;
    rq.weight_grad   = gw;
    rq.bias_grad     = gb;
    pending_requests.insert(pending_requests.size(), rq);
  endtask

  task automatic queue_random(int count);
    int idx;
    for (int n = 0; n < count; n++) begin
      // Mostly revisit a few elements so the averages build up over time.
      idx = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 7) * 37 : $urandom_range(0, 255);
      queue_request(idx, pick_value(), pick_value(), pick_value(), pick_value());
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_updates.size() != 0);
    repeat (LAT_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == REG_MODE) begin
      upd_mode = val[1:0];
      clear_averages();
    end else if (idx == REG_DECAY) begin
      upd_decay = val[15:0];
    end else if (idx == REG_RATE) begin
      upd_rate = val;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(logic [23:0] m, logic [23:0] d, logic [23:0] r);
    wait_drained();
    write_reg(REG_DECAY, d);
    write_reg(REG_RATE, r);
    write_reg(REG_MODE, m);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_MODE;
    cfg_data = '0;
    mismatches = 0;
    results_seen = 0;
    idle_cycles = 0;
    quiet = 0;
    long_hold_req = 0;
    sender_hold = 0;
    tx_gap = 0;
    rx_left = 0;
    upd_mode = MODE_PLAIN;
    upd_decay = DECAY_RST;
    upd_rate = RATE_RST;
    clear_averages();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Plain add at reset settings: saturation in both directions, index ends.
    queue_request(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_request(255, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_request(1, 0, 0, 0, 0);
    queue_request(2, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001);
    queue_random(RAND_ITEMS);

    // Momentum with reset decay and rate; same element repeatedly.
    configure(MODE_MOMENTUM, DECAY_RST, RATE_RST);
    repeat (3) queue_request(5, 0, 0, 32'h0100_0000, 32'hFF00_0000);
    queue_request(5, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_random(RAND_ITEMS);

    // Adaptive: zero store gives the bare epsilon divisor, then extreme changes.
    configure(MODE_ADAPTIVE, DECAY_RST, RATE_RST);
    queue_request(9, 100, -100, 0, 0);
    queue_request(9, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_request(9, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_request(10, 0, 0, 1, -1);
    queue_random(RAND_ITEMS / 2);
    // Hold results off so the pipeline backs up into the request side.
    long_hold_req = 1;
    queue_random(RAND_ITEMS / 2);

    // Extremes of decay and rate; the mode write carries extra high bits.
    configure(24'hFFFF_FE, 16'hFFFF, 24'hFF_FFFF);
    queue_request(3, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_random(RAND_ITEMS);

    configure(MODE_MOMENTUM, 0, 0);
    queue_request(3, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_random(RAND_ITEMS);

    // Writes to the unused register index are dropped; mode 3 acts as plain add.
    configure(MODE_SPARE, 24'h12_3456, 24'h00_0001);
    write_reg(REG_SPARE, 24'hFF_FFFF);
    queue_request(4, 32'h7FFF_FFFF, 0, 1, 0);
    quiet = 1;
    queue_random(RAND_ITEMS / 2);
    wait_drained();
    quiet = 0;
    queue_random(RAND_ITEMS / 2);

    // Adaptive with the sender paused mid-stream until everything is back.
    configure(MODE_ADAPTIVE, 16'h8000, 24'h80_0000);
    queue_random(RAND_ITEMS / 2);
    sender_hold = 1;
    do @(posedge clk);
    while (in_valid || expected_updates.size() != 0);
    sender_hold = 0;
    queue_random(RAND_ITEMS / 2);

    wait_drained();
    if (expected_updates.size() != 0) mismatches++;
    $display("Checked %0d updates over plain, momentum and adaptive settings", results_seen);
    $display("including saturation, register extremes and back-pressure; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("optimizer_parameter_update_core test passed");
    end else begin
      $display("optimizer_parameter_update_core test failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/opu_pkg.sv
rtl/core/opu_avg_update.sv
rtl/core/opu_isqrt.sv
rtl/core/opu_div.sv
rtl/core/optimizer_parameter_update_core.sv
bench/optimizer_parameter_update_core_tb.sv
